// ----- src/kss_pkg.sv -----
// shared types and constants for the plucked string voice
// no dependencies; used by kss_ram users and the top level
package kss_pkg;

  localparam int LINE_DEPTH  = 4096;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 24;

  localparam int DELAY_BITS    = 12;
  localparam int GAIN_BITS     = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;

  // smoother state widths: delay is 12.24, gain is 1.24
  localparam int DSM_BITS = DELAY_BITS + FRAC_BITS;
  localparam int GSM_BITS = 1 + FRAC_BITS;

  localparam int DCOEF_BITS = 11;
  localparam int GCOEF_BITS = 15;
  localparam logic [DCOEF_BITS-1:0] DELAY_COEF = 11'd1678;
  localparam logic [GCOEF_BITS-1:0] GAIN_COEF  = 15'd16777;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 12'd2000;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd26214;
  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY  = 16'd32768;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_TARGET  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] audio_word_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SMUL = 7'b0000010,
    ST_SUPD = 7'b0000100,
    ST_RD0  = 7'b0001000,
    ST_RD1  = 7'b0010000,
    ST_MUL  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

// ----- src/kss_ram.sv -----
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
module kss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/karplus_strong_string_voice_unit.sv -----
// plucked string voice: feedback delay line with smoothed delay and gain
// depends on kss_pkg and kss_ram
// sequence: after an input transfer the sequencer steps the smoothers, makes two line reads on the
//   one ram read port, does the feedback multiply, then loads the output and writes back, waiting there
//   while the output is full; the skid register can take the next sample while an item is in work
// reset: synchronous, clears smoothers, write pointer, fill flag and handshakes;
//   no clearing pass, entries not yet written read as zero through the fill count
module karplus_strong_string_voice_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [kss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [kss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [kss_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,  // [23:0] sample_in
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [kss_pkg::SAMPLE_BITS-1:0]     m_axis_tdata   // [23:0] sample_out
);

  localparam int SB  = kss_pkg::SAMPLE_BITS;
  localparam int AW  = kss_pkg::LINE_AW;
  localparam int FB  = kss_pkg::FRAC_BITS;
  localparam int DSB = kss_pkg::DSM_BITS;
  localparam int GSB = kss_pkg::GSM_BITS;
  localparam int DPB = DSB + kss_pkg::DCOEF_BITS;   // delay smoother product
  localparam int GPB = GSB + kss_pkg::GCOEF_BITS;   // gain smoother product
  localparam int SUMB = SB + 1;                     // sum of two taps
  localparam int FPB  = GSB + 1 + SUMB;             // feedback product, signed
  localparam int FBB  = FPB - (FB + 1);             // feedback term after shift
  localparam int YB   = FBB + 1;                    // sum before saturation

  // saturation limits at the sample width
  localparam logic signed [YB-1:0] Y_MAX = YB'((1 << (SB-1)) - 1);
  localparam logic signed [YB-1:0] Y_MIN = YB'(-(1 << (SB-1)));

  // configuration registers, clamped on write
  logic [kss_pkg::DELAY_BITS-1:0] delay_length;
  logic [kss_pkg::GAIN_BITS-1:0]  gain_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= kss_pkg::DELAY_RESET;
      gain_target  <= kss_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        kss_pkg::REG_DELAY_LENGTH: begin
          // a zero delay is stored as one sample
          if (cfg_data[kss_pkg::DELAY_BITS-1:0] == '0) begin
            delay_length <= kss_pkg::DELAY_BITS'(1);
          end else begin
            delay_length <= cfg_data[kss_pkg::DELAY_BITS-1:0];
          end
        end
        kss_pkg::REG_GAIN_TARGET: begin
          // gain above unity is held at unity
          if (cfg_data[kss_pkg::GAIN_BITS-1:0] > kss_pkg::GAIN_UNITY) begin
            gain_target <= kss_pkg::GAIN_UNITY;
          end else begin
            gain_target <= cfg_data[kss_pkg::GAIN_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // input skid register: takes a new transfer while the sequencer is busy
  logic            in_full;
  kss_pkg::audio_word_t in_data;
  logic            in_take;

  assign s_axis_tready = !in_full;

  // sequencer
  kss_pkg::state_t state, state_next;

  // per-item registers
  kss_pkg::audio_word_t x;
  logic [DSB-1:0]   delay_smooth;
  logic [GSB-1:0]   gain_smooth;
  logic [DPB-1:0]   dprod;
  logic [GPB-1:0]   gprod;
  logic             d_up, d_dn, g_up, g_dn;
  logic [AW-1:0]    write_pos;
  logic             wrapped;      // every entry has been written at least once
  logic [AW-1:0]    rp1;
  logic             valid0, valid1;
  logic [SB-1:0]    line0;
  logic signed [FPB-1:0] fprod;

  // output register
  logic             out_valid;
  kss_pkg::audio_word_t out_data;
  logic             out_load;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // smoother targets and distances
  logic [DSB-1:0] d_target, d_diff;
  logic [GSB-1:0] g_target, g_diff;
  logic [DPB-FB-1:0] d_stepv;
  logic [GPB-FB-1:0] g_stepv;

  assign d_target = {delay_length, {FB{1'b0}}};
  assign g_target = GSB'({gain_target, 9'b0});
  assign d_diff   = (d_target > delay_smooth) ? (d_target - delay_smooth)
                                              : (delay_smooth - d_target);
  assign g_diff   = (g_target > gain_smooth) ? (g_target - gain_smooth)
                                             : (gain_smooth - g_target);
  // ceil of product over 2^24, so the smoother lands exactly on its target
  assign d_stepv  = (DPB-FB)'(DPB'(dprod + DPB'((1 << FB) - 1)) >> FB);
  assign g_stepv  = (GPB-FB)'(GPB'(gprod + GPB'((1 << FB) - 1)) >> FB);

  // read pointers from the integer part of the smoothed delay, modulo the depth
  logic [AW-1:0] rp_calc;
  assign rp_calc = write_pos - delay_smooth[FB +: AW];

  // ram ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [SB-1:0] rd_data;
  logic          wr_en;

  // feedback arithmetic
  logic signed [SUMB-1:0] tap0, tap1, tap_sum;
  logic signed [FPB-1:0]  fround;
  logic signed [FBB-1:0]  fb;
  logic signed [YB-1:0]   y_wide;
  kss_pkg::audio_word_t   y_sat;

  assign tap0    = valid0 ? SUMB'($signed(line0)) : '0;
  assign tap1    = valid1 ? SUMB'($signed(rd_data)) : '0;
  assign tap_sum = tap0 + tap1;

  // round half up: floor((p + 2^24) / 2^25)
  assign fround  = fprod + FPB'(1 << FB);
  assign fb      = fround[FPB-1 -: FBB];
  assign y_wide  = YB'(x) + YB'(fb);

  always_comb begin
    if (y_wide > Y_MAX) begin
      y_sat = Y_MAX[SB-1:0];
    end else if (y_wide < Y_MIN) begin
      y_sat = Y_MIN[SB-1:0];
    end else begin
      y_sat = y_wide[SB-1:0];
    end
  end

  // output register may load when empty or being drained this cycle
  assign out_load = (state == kss_pkg::ST_OUT) && (!out_valid || m_axis_tready);
  assign wr_en    = out_load;
  assign in_take  = (state == kss_pkg::ST_IDLE) && in_full;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rp_calc;
    unique case (state)
      kss_pkg::ST_RD0: begin
        rd_en   = 1'b1;
        rd_addr = rp_calc;
      end
      kss_pkg::ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = rp1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kss_pkg::ST_IDLE: if (in_full) state_next = kss_pkg::ST_SMUL;
      kss_pkg::ST_SMUL: state_next = kss_pkg::ST_SUPD;
      kss_pkg::ST_SUPD: state_next = kss_pkg::ST_RD0;
      kss_pkg::ST_RD0:  state_next = kss_pkg::ST_RD1;
      kss_pkg::ST_RD1:  state_next = kss_pkg::ST_MUL;
      kss_pkg::ST_MUL:  state_next = kss_pkg::ST_OUT;
      kss_pkg::ST_OUT:  if (out_load) state_next = kss_pkg::ST_IDLE;
      default:          state_next = kss_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kss_pkg::ST_IDLE;
      in_full      <= 1'b0;
      out_valid    <= 1'b0;
      delay_smooth <= '0;
      gain_smooth  <= '0;
      write_pos    <= '0;
      wrapped      <= 1'b0;
    end else begin
      state <= state_next;
      if (s_axis_tvalid && s_axis_tready) begin
        in_full <= 1'b1;
      end else if (in_take) begin
        in_full <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == kss_pkg::ST_SUPD) begin
        if (d_up) begin
          delay_smooth <= delay_smooth + DSB'(d_stepv);
        end else if (d_dn) begin
          delay_smooth <= delay_smooth - DSB'(d_stepv);
        end
        if (g_up) begin
          gain_smooth <= gain_smooth + GSB'(g_stepv);
        end else if (g_dn) begin
          gain_smooth <= gain_smooth - GSB'(g_stepv);
        end
      end
      if (out_load) begin
        write_pos <= write_pos + AW'(1);
        if (write_pos == '1) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
    if (in_take) begin
      x <= in_data;
    end
    if (state == kss_pkg::ST_SMUL) begin
      dprod <= d_diff * kss_pkg::DELAY_COEF;
      gprod <= g_diff * kss_pkg::GAIN_COEF;
      d_up  <= d_target > delay_smooth;
      d_dn  <= d_target < delay_smooth;
      g_up  <= g_target > gain_smooth;
      g_dn  <= g_target < gain_smooth;
    end
    if (state == kss_pkg::ST_RD0) begin
      // an entry below the write pointer has been written, all are once wrapped
      rp1    <= rp_calc - AW'(1);
      valid0 <= wrapped || (rp_calc < write_pos);
      valid1 <= wrapped || ((rp_calc - AW'(1)) < write_pos);
    end
    if (state == kss_pkg::ST_RD1) begin
      line0 <= rd_data;
    end
    if (state == kss_pkg::ST_MUL) begin
      fprod <= FPB'($signed({1'b0, gain_smooth}) * tap_sum);
    end
    if (out_load) begin
      out_data <= y_sat;
    end
  end

  // the delay line; writes land well before any later item reads
  kss_ram #(
    .WIDTH(SB),
    .DEPTH(kss_pkg::LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_pos),
    .wr_data (y_sat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
